[hdl/htwd_pkg.sv]
// ----------------------------------------------------------------------------
// htwd_pkg
// Shared types, sizes and codes of the Huffman tree-walk decoder.
// ----------------------------------------------------------------------------
package htwd_pkg;

	// Node table size and the address width that follows from it.
	localparam int NODE_COUNT = 512;
	localparam int ADDR_W     = $clog2(NODE_COUNT);

	// Fixed field widths.
	localparam int IDX_W   = 9;
	localparam int SYM_W   = 8;
	localparam int CNT_W   = 31;
	localparam int NBITS_W = 4;

	// Bits of one compressed byte, taken most significant first.
	localparam int BYTE_BITS = 8;
	localparam int TOP_BIT   = 7;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ROOT  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	// Operation codes of an input transaction; code 3 is unused.
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_START  = 2'd1,
		OP_DECODE = 2'd2
	} op_t;

	// One node table entry.
	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             leaf;
		logic [SYM_W-1:0] sym;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	// Decoded input transaction handed to the walk engine.
	typedef struct packed {
		logic               load;
		logic               restart;
		logic               decode;
		logic [IDX_W-1:0]   node_index;
		node_t              node;
		logic [SYM_W-1:0]   data_byte;
		logic [NBITS_W-1:0] valid_bits;
	} cmd_t;

	// Event from the walk engine to the result stage.
	typedef struct packed {
		logic             hit;
		logic             flush;
		logic [SYM_W-1:0] sym;
		logic             done;
	} emit_ev_t;

	// Walk engine states.
	typedef enum logic [1:0] {
		WS_IDLE,
		WS_BIT,
		WS_FETCH,
		WS_CHILD
	} walk_state_t;

	// True when a node index lies inside the table.
	function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
		return {{(32-IDX_W){1'b0}}, idx} < 32'(NODE_COUNT);
	endfunction

endpackage

[hdl/huffman_tree_walk_decoder.sv]
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Huffman decoder that walks a loaded code tree, one node read per bit.
// ----------------------------------------------------------------------------
// Usage: an input transaction is taken when start is high and busy is low.
// operation selects a node table load, the start of a new stream (walk back
// at root_node, symbol count cleared) or the decode of one compressed byte.
// Loads and starts leave busy low. A decode walks valid_bits bits (at most
// eight) most significant first, stopping early once the symbol limit is
// reached; each bit takes a node memory read and an evaluation, because
// every step needs the node read in the step before. A leaf reached through
// a child adds a refetch of the root, and the byte ends with a step that
// finds no bits left or the limit reached. The first byte after reset, a
// load or a start also begins by refetching the current node. Each decoded
// symbol appears on symbol for one cycle with result_valid high; it is shown
// after the next symbol is found or, for the last one of a byte, in the
// first cycle after busy falls, with last_of_byte set. The receiver cannot
// stall results. Registers are to be written over the APB-style port only
// while no decode is in flight; the block itself does not enforce this.
// Reset clears the registers, the walk position and the symbol count; node
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      operation,
	input  logic [htwd_pkg::IDX_W-1:0]      node_index,
	input  logic [htwd_pkg::IDX_W-1:0]      left_child,
	input  logic [htwd_pkg::IDX_W-1:0]      right_child,
	input  logic                            is_leaf,
	input  logic [htwd_pkg::SYM_W-1:0]      leaf_symbol,
	input  logic [htwd_pkg::SYM_W-1:0]      data_byte,
	input  logic [htwd_pkg::NBITS_W-1:0]    valid_bits,
	output logic                            result_valid,
	output logic [htwd_pkg::SYM_W-1:0]      symbol,
	output logic                            last_of_byte,
	output logic                            stream_done,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [htwd_pkg::PADDR_W-1:0]    paddr,
	input  logic [htwd_pkg::PDATA_W-1:0]    pwdata,
	output logic [htwd_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);

	logic                       accept;
	logic                       walk_busy;
	logic [htwd_pkg::IDX_W-1:0] root_node;
	logic [htwd_pkg::CNT_W-1:0] symbol_limit;
	htwd_pkg::cmd_t             cmd;
	htwd_pkg::emit_ev_t         ev;

	htwd_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.root_node   (root_node),
		.symbol_limit(symbol_limit)
	);

	// Decode the accepted transaction into a command.
	assign accept = start & ~walk_busy;

	always_comb begin
		cmd.load       = accept && (operation == htwd_pkg::OP_LOAD);
		cmd.restart    = accept && (operation == htwd_pkg::OP_START);
		cmd.decode     = accept && (operation == htwd_pkg::OP_DECODE);
		cmd.node_index = node_index;
		cmd.node.left  = left_child;
		cmd.node.right = right_child;
		cmd.node.leaf  = is_leaf;
		cmd.node.sym   = leaf_symbol;
		cmd.data_byte  = data_byte;
		cmd.valid_bits = valid_bits;
	end

	htwd_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.root_node   (root_node),
		.symbol_limit(symbol_limit),
		.busy        (walk_busy),
		.ev          (ev)
	);

	htwd_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev          (ev),
		.result_valid(result_valid),
		.symbol      (symbol),
		.last_of_byte(last_of_byte),
		.stream_done (stream_done)
	);

	assign busy = walk_busy;

endmodule

[hdl/htwd_ram.sv]
// ----------------------------------------------------------------------------
// htwd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module htwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/htwd_cfg.sv]
// ----------------------------------------------------------------------------
// htwd_cfg
// Configuration registers behind an APB-style port: root index and limit.
// ----------------------------------------------------------------------------
module htwd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [htwd_pkg::PADDR_W-1:0]  paddr,
	input  logic [htwd_pkg::PDATA_W-1:0]  pwdata,
	output logic [htwd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [htwd_pkg::IDX_W-1:0]    root_node,
	output logic [htwd_pkg::CNT_W-1:0]    symbol_limit
);

	logic [htwd_pkg::IDX_W-1:0] root_node_q;
	logic [htwd_pkg::CNT_W-1:0] symbol_limit_q;
	logic                       wr_en;
	logic                       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_node_q    <= '0;
			symbol_limit_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				htwd_pkg::REG_ROOT:  root_node_q    <= pwdata[htwd_pkg::IDX_W-1:0];
				htwd_pkg::REG_LIMIT: symbol_limit_q <= pwdata[htwd_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		case (reg_sel)
			htwd_pkg::REG_ROOT:
				prdata = htwd_pkg::PDATA_W'(root_node_q);
			htwd_pkg::REG_LIMIT:
				prdata = htwd_pkg::PDATA_W'(symbol_limit_q);
			default:
				prdata = '0;
		endcase
	end

	assign root_node    = root_node_q;
	assign symbol_limit = symbol_limit_q;

endmodule

[hdl/htwd_walk.sv]
// ----------------------------------------------------------------------------
// htwd_walk
// Tree-walk engine: holds the node table memory, walks one bit per node read
// and evaluation, refetches the root after a leaf found below a node,
// and reports every leaf reached and the end of each byte.
// ----------------------------------------------------------------------------
module htwd_walk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  htwd_pkg::cmd_t             cmd,
	input  logic [htwd_pkg::IDX_W-1:0] root_node,
	input  logic [htwd_pkg::CNT_W-1:0] symbol_limit,
	output logic                       busy,
	output htwd_pkg::emit_ev_t         ev
);

	htwd_pkg::walk_state_t state_q, state_nxt;

	logic [htwd_pkg::IDX_W-1:0]   cur_node_q;
	htwd_pkg::node_t              cur_entry_q;
	logic                         cur_valid_q;
	logic [htwd_pkg::SYM_W-1:0]   data_q;
	logic [htwd_pkg::NBITS_W-1:0] bits_left_q;
	logic [htwd_pkg::CNT_W-1:0]   count_q;
	logic                         rd_ok_s1;

	logic [htwd_pkg::IDX_W-1:0]   rd_idx;
	logic [htwd_pkg::NODE_W-1:0]  rd_data;
	htwd_pkg::node_t              node_rd;
	logic [htwd_pkg::CNT_W-1:0]   count_nxt;
	logic                         stop;
	logic                         hit;
	logic                         finish;
	logic                         consume;
	logic [htwd_pkg::SYM_W-1:0]   hit_sym;
	logic [htwd_pkg::NBITS_W-1:0] nbits_clamped;

	// Node table memory; loads are written straight from the command.
	htwd_ram #(
		.WIDTH(htwd_pkg::NODE_W),
		.DEPTH(htwd_pkg::NODE_COUNT)
	) u_node_ram (
		.clk  (clk),
		.we   (cmd.load & htwd_pkg::idx_ok(cmd.node_index)),
		.waddr(htwd_pkg::ADDR_W'(cmd.node_index)),
		.wdata(cmd.node),
		.raddr(htwd_pkg::ADDR_W'(rd_idx)),
		.rdata(rd_data)
	);

	// An index outside the table reads as an all-zero inner node.
	assign node_rd   = rd_ok_s1 ? htwd_pkg::node_t'(rd_data) : '0;
	assign count_nxt = count_q + htwd_pkg::CNT_W'(1);
	assign stop      = (bits_left_q == '0) || (count_q >= symbol_limit);
	assign busy      = (state_q != htwd_pkg::WS_IDLE);

	assign nbits_clamped = (cmd.valid_bits > htwd_pkg::NBITS_W'(htwd_pkg::BYTE_BITS)) ?
		htwd_pkg::NBITS_W'(htwd_pkg::BYTE_BITS) : cmd.valid_bits;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			htwd_pkg::WS_IDLE: begin
				if (cmd.decode) begin
					state_nxt = htwd_pkg::WS_BIT;
				end
			end
			htwd_pkg::WS_BIT: begin
				if (stop) begin
					state_nxt = htwd_pkg::WS_IDLE;
				end else if (!cur_valid_q || cur_entry_q.leaf) begin
					state_nxt = htwd_pkg::WS_FETCH;
				end else begin
					state_nxt = htwd_pkg::WS_CHILD;
				end
			end
			htwd_pkg::WS_FETCH: state_nxt = htwd_pkg::WS_BIT;
			htwd_pkg::WS_CHILD: begin
				state_nxt = node_rd.leaf ? htwd_pkg::WS_FETCH : htwd_pkg::WS_BIT;
			end
			default: state_nxt = htwd_pkg::WS_IDLE;
		endcase
	end

	// Read address and per-bit decisions.
	always_comb begin
		rd_idx  = cur_node_q;
		hit     = 1'b0;
		finish  = 1'b0;
		consume = 1'b0;
		hit_sym = cur_entry_q.sym;
		case (state_q)
			htwd_pkg::WS_BIT: begin
				if (stop) begin
					finish = 1'b1;
				end else if (!cur_valid_q) begin
					rd_idx = cur_node_q;
				end else if (cur_entry_q.leaf) begin
					// The current node is itself a leaf: emit it, stay at the root.
					hit     = 1'b1;
					consume = 1'b1;
					rd_idx  = root_node;
				end else begin
					rd_idx = data_q[htwd_pkg::TOP_BIT] ? cur_entry_q.right : cur_entry_q.left;
				end
			end
			htwd_pkg::WS_CHILD: begin
				// Fetch the root early in case the child turns out to be a leaf.
				consume = 1'b1;
				rd_idx  = root_node;
				hit     = node_rd.leaf;
				hit_sym = node_rd.sym;
			end
			htwd_pkg::WS_IDLE,
			htwd_pkg::WS_FETCH: rd_idx = cur_node_q;
			default: rd_idx = cur_node_q;
		endcase
	end

	assign ev.hit   = hit;
	assign ev.flush = finish;
	assign ev.sym   = hit_sym;
	assign ev.done  = (count_nxt >= symbol_limit);

	// Control registers of the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= htwd_pkg::WS_IDLE;
			cur_node_q  <= '0;
			cur_valid_q <= 1'b0;
			count_q     <= '0;
			bits_left_q <= '0;
			rd_ok_s1    <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			rd_ok_s1 <= htwd_pkg::idx_ok(rd_idx);
			if (state_q == htwd_pkg::WS_IDLE) begin
				if (cmd.load) begin
					cur_valid_q <= 1'b0;
				end
				if (cmd.restart) begin
					cur_node_q  <= root_node;
					count_q     <= '0;
					cur_valid_q <= 1'b0;
				end
				if (cmd.decode) begin
					bits_left_q <= nbits_clamped;
				end
			end else begin
				if (consume) begin
					bits_left_q <= bits_left_q - htwd_pkg::NBITS_W'(1);
				end
				if (hit) begin
					cur_node_q  <= root_node;
					count_q     <= count_nxt;
					cur_valid_q <= 1'b0;
				end else if (state_q == htwd_pkg::WS_CHILD ||
					state_q == htwd_pkg::WS_FETCH) begin
					cur_valid_q <= 1'b1;
				end else if (state_q == htwd_pkg::WS_BIT && !stop && cur_valid_q) begin
					cur_node_q <= rd_idx;
				end
			end
		end
	end

	// Cached entry of the current node and the byte being walked.
	always_ff @(posedge clk) begin
		if (state_q == htwd_pkg::WS_IDLE && cmd.decode) begin
			data_q <= cmd.data_byte;
		end else if (consume) begin
			data_q <= {data_q[htwd_pkg::TOP_BIT-1:0], 1'b0};
		end
		if (state_q == htwd_pkg::WS_FETCH ||
			(state_q == htwd_pkg::WS_CHILD && !node_rd.leaf)) begin
			cur_entry_q <= node_rd;
		end
	end

	// A fetch is always followed by the evaluation of that node.
	a_fetch_then_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == htwd_pkg::WS_FETCH |=> state_q == htwd_pkg::WS_BIT)
		else $error("fetch not followed by bit evaluation");

	// After a child read the walk either refetches the root or evaluates.
	a_child_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == htwd_pkg::WS_CHILD |=>
			(state_q == htwd_pkg::WS_BIT || state_q == htwd_pkg::WS_FETCH))
		else $error("bad exit from child read");

	// No symbol is emitted once the limit is reached.
	a_hit_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> count_q < symbol_limit)
		else $error("symbol emitted past the limit");

	// The bit counter never exceeds one byte.
	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q <= htwd_pkg::NBITS_W'(htwd_pkg::BYTE_BITS))
		else $error("bit counter out of range");

endmodule

[hdl/htwd_emit.sv]
// ----------------------------------------------------------------------------
// htwd_emit
// Result stage: holds the newest symbol back until the next one or the end
// of the byte shows whether it is the last, then drives the result strobe.
// ----------------------------------------------------------------------------
module htwd_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  htwd_pkg::emit_ev_t         ev,
	output logic                       result_valid,
	output logic [htwd_pkg::SYM_W-1:0] symbol,
	output logic                       last_of_byte,
	output logic                       stream_done
);

	logic                       pend_valid_q;
	logic [htwd_pkg::SYM_W-1:0] pend_sym_q;
	logic                       pend_done_q;
	logic                       out_valid_q;
	logic [htwd_pkg::SYM_W-1:0] out_sym_q;
	logic                       out_last_q;
	logic                       out_done_q;

	// Pending flag and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= pend_valid_q & (ev.hit | ev.flush);
			if (ev.hit) begin
				pend_valid_q <= 1'b1;
			end else if (ev.flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (ev.hit || ev.flush) begin
			out_sym_q  <= pend_sym_q;
			out_done_q <= pend_done_q;
			out_last_q <= ev.flush;
		end
		if (ev.hit) begin
			pend_sym_q  <= ev.sym;
			pend_done_q <= ev.done;
		end
	end

	assign result_valid = out_valid_q;
	assign symbol       = out_sym_q;
	assign last_of_byte = out_last_q;
	assign stream_done  = out_done_q;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the Huffman tree-walk decoder.
// Walks only ever reach loaded nodes: random roots are drawn from loaded
// entries, and every inner node that is written points at loaded nodes.
// A short table of directed transactions covers the reset state, a leaf root,
// bit counts of zero and above eight, the unused operation, the symbol limit
// and the register extremes. Random phases follow: most build a proper code
// tree, then each sets the registers, starts a stream and decodes random bytes
// mixed with noise. Every result is compared field by field with a typed
// row's expectation or with a symbol-level tree-walk model kept in this file.
// ----------------------------------------------------------------------------
module tb_top;

	import htwd_pkg::*;

	localparam int RAND_ITEMS   = 200;
	localparam int CALM_TAIL    = 40;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 2000;

	// Operation code that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One input transaction, every field at its port width.
	typedef struct packed {
		logic [1:0]         op;
		logic [IDX_W-1:0]   idx;
		logic [IDX_W-1:0]   lft;
		logic [IDX_W-1:0]   rgt;
		logic               leaf;
		logic [SYM_W-1:0]   lsym;
		logic [SYM_W-1:0]   data;
		logic [NBITS_W-1:0] nbits;
	} dec_item_t;

	// One decoded symbol as it should appear on the result ports.
	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
		logic             done;
	} sym_res_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct packed {
		row_kind_t        kind;
		dec_item_t        item;
		logic             reg_sel;
		logic [31:0]      reg_val;
		logic             typed;
		logic [3:0]       exp_n;
		logic [SYM_W-1:0] exp_sym;
		logic             exp_done;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           operation;
	logic [IDX_W-1:0]     node_index;
	logic [IDX_W-1:0]     left_child;
	logic [IDX_W-1:0]     right_child;
	logic                 is_leaf;
	logic [SYM_W-1:0]     leaf_symbol;
	logic [SYM_W-1:0]     data_byte;
	logic [NBITS_W-1:0]   valid_bits;
	logic                 result_valid;
	logic [SYM_W-1:0]     symbol;
	logic                 last_of_byte;
	logic                 stream_done;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// Walk model state: node table, position, count and registers.
	logic [IDX_W-1:0]     tree_left  [0:NODE_COUNT-1];
	logic [IDX_W-1:0]     tree_right [0:NODE_COUNT-1];
	logic                 tree_leaf  [0:NODE_COUNT-1];
	logic [SYM_W-1:0]     tree_sym   [0:NODE_COUNT-1];
	bit                   node_loaded [0:NODE_COUNT-1];
	logic [IDX_W-1:0]     walk_pos;
	logic [CNT_W-1:0]     sym_count;
	logic [IDX_W-1:0]     root_reg;
	logic [CNT_W-1:0]     limit_reg;

	sym_res_t             expected_syms [$];
	sym_res_t             step_syms [$];
	sym_res_t             want_res;
	dir_row_t             dir_tab [$];
	int                   err_cnt = 0;
	int                   rand_items = 0;
	int                   quiet_cycles = 0;
	logic                 no_idle = 1'b0;

	huffman_tree_walk_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.node_index   (node_index),
		.left_child   (left_child),
		.right_child  (right_child),
		.is_leaf      (is_leaf),
		.leaf_symbol  (leaf_symbol),
		.data_byte    (data_byte),
		.valid_bits   (valid_bits),
		.result_valid (result_valid),
		.symbol       (symbol),
		.last_of_byte (last_of_byte),
		.stream_done  (stream_done),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the walk model by one transaction and collect its symbols.
	task automatic decode_symbols(input dec_item_t it);
		int       nb;
		int       b;
		logic     bitv;
		logic     hit;
		logic     have;
		logic [SYM_W-1:0] s;
		sym_res_t held;
		step_syms.delete();
		have = 1'b0;
		held = '0;
		case (it.op)
			OP_LOAD: begin
				tree_left[it.idx]   = it.lft;
				tree_right[it.idx]  = it.rgt;
				tree_leaf[it.idx]   = it.leaf;
				tree_sym[it.idx]    = it.lsym;
				node_loaded[it.idx] = 1'b1;
			end
			OP_START: begin
				walk_pos  = root_reg;
				sym_count = '0;
			end
			OP_DECODE: begin
				nb = (it.nbits > BYTE_BITS) ? BYTE_BITS : it.nbits;
				for (b = 0; b < nb && sym_count < limit_reg; b++) begin
					bitv = it.data[TOP_BIT - b];
					// A leaf under the walk position emits without moving.
					if (tree_leaf[walk_pos]) begin
						s   = tree_sym[walk_pos];
						hit = 1'b1;
					end else begin
						walk_pos = bitv ? tree_right[walk_pos] : tree_left[walk_pos];
						s        = tree_sym[walk_pos];
						hit      = tree_leaf[walk_pos];
					end
					if (hit) begin
						walk_pos  = root_reg;
						sym_count = sym_count + 1'b1;
						if (have)
							step_syms.push_back(held);
						held.sym  = s;
						held.last = 1'b0;
						held.done = (sym_count >= limit_reg);
						have      = 1'b1;
					end
				end
				// The final symbol of the byte carries last_of_byte.
				if (have) begin
					held.last = 1'b1;
					step_syms.push_back(held);
				end
			end
			default: ;
		endcase
	endtask

	function automatic dec_item_t random_item();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(dec_item_t)-1:0];
	endfunction

	// Pick a random node index that has already been loaded.
	function automatic logic [IDX_W-1:0] pick_loaded();
		logic [IDX_W-1:0] idx;
		do
			idx = IDX_W'($urandom_range(0, NODE_COUNT - 1));
		while (!node_loaded[idx]);
		return idx;
	endfunction

	function automatic dir_row_t load_row(input logic [IDX_W-1:0] idx, lft, rgt,
		input logic leaf, input logic [SYM_W-1:0] lsym);
		dir_row_t r;
		r = '0;
		r.kind      = ROW_ITEM;
		r.item.op   = OP_LOAD;
		r.item.idx  = idx;
		r.item.lft  = lft;
		r.item.rgt  = rgt;
		r.item.leaf = leaf;
		r.item.lsym = lsym;
		return r;
	endfunction

	function automatic dir_row_t byte_row(input logic [1:0] op, input logic [SYM_W-1:0] data,
		input logic [NBITS_W-1:0] nbits, input logic typed, input logic [3:0] n,
		input logic [SYM_W-1:0] esym, input logic edone);
		dir_row_t r;
		r = '0;
		r.kind       = ROW_ITEM;
		r.item.op    = op;
		r.item.data  = data;
		r.item.nbits = nbits;
		r.typed      = typed;
		r.exp_n      = n;
		r.exp_sym    = esym;
		r.exp_done   = edone;
		return r;
	endfunction

	function automatic dir_row_t reg_row(input logic sel, input logic [31:0] val);
		dir_row_t r;
		r = '0;
		r.kind    = ROW_REG;
		r.reg_sel = sel;
		r.reg_val = val;
		return r;
	endfunction

	// Present one transaction and wait for the block to take it.
	task automatic send_item(input dec_item_t it, input logic typed, input logic [3:0] n,
		input logic [SYM_W-1:0] esym, input logic edone);
		sym_res_t r;
		start       <= 1'b1;
		operation   <= it.op;
		node_index  <= it.idx;
		left_child  <= it.lft;
		right_child <= it.rgt;
		is_leaf     <= it.leaf;
		leaf_symbol <= it.lsym;
		data_byte   <= it.data;
		valid_bits  <= it.nbits;
		do
			@(posedge clk);
		while (busy);
		decode_symbols(it);
		if (typed) begin
			for (int k = 0; k < n; k++) begin
				r.sym  = esym;
				r.last = (k == n - 1);
				r.done = (k == n - 1) ? edone : 1'b0;
				expected_syms.push_back(r);
			end
		end else begin
			foreach (step_syms[k])
				expected_syms.push_back(step_syms[k]);
		end
		if (it.op != OP_UNUSED)
			rand_items++;
	endtask

	// Random idle burst on the sender side.
	task automatic idle_gap();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Hold off until every expected symbol has arrived and the walk is over.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_syms.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register, then read it back.
	task automatic reg_access(input logic sel, input logic [31:0] val);
		logic [PDATA_W-1:0] exp_rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (sel == REG_ROOT)
			root_reg = val[IDX_W-1:0];
		else
			limit_reg = val[CNT_W-1:0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		exp_rd = (sel == REG_ROOT) ? {{(PDATA_W-IDX_W){1'b0}}, root_reg}
			: {{(PDATA_W-CNT_W){1'b0}}, limit_reg};
		if (prdata !== exp_rd) begin
			$display("%0t: register %0d readback, expected %0h, got %0h",
				$time, sel, exp_rd, prdata);
			err_cnt++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Load a random full code tree with the given number of leaves.
	task automatic build_tree(input int leaves, output logic [IDX_W-1:0] top);
		bit               taken [0:NODE_COUNT-1];
		logic [IDX_W-1:0] pool [$];
		logic [IDX_W-1:0] idx;
		int               p;
		dec_item_t        it;
		foreach (taken[k])
			taken[k] = 1'b0;
		for (int k = 0; k < 2 * leaves - 1; k++) begin
			do
				idx = IDX_W'($urandom_range(0, NODE_COUNT - 1));
			while (taken[idx]);
			taken[idx] = 1'b1;
			it     = random_item();
			it.op  = OP_LOAD;
			it.idx = idx;
			if (k < leaves) begin
				it.leaf = 1'b1;
			end else begin
				// Join two subtrees under a new inner node.
				it.leaf = 1'b0;
				p       = $urandom_range(0, pool.size() - 1);
				it.lft  = pool[p];
				pool.delete(p);
				p       = $urandom_range(0, pool.size() - 1);
				it.rgt  = pool[p];
				pool.delete(p);
			end
			pool.push_back(idx);
			send_item(it, 1'b0, 4'd0, '0, 1'b0);
			idle_gap();
		end
		top = pool[0];
	endtask

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_syms.size() == 0) begin
				$display("%0t: result without expectation, expected none, got symbol %0h",
					$time, symbol);
				err_cnt++;
			end else begin
				want_res = expected_syms.pop_front();
				if (symbol !== want_res.sym) begin
					$display("%0t: symbol, expected %0h, got %0h", $time, want_res.sym, symbol);
					err_cnt++;
				end
				if (last_of_byte !== want_res.last) begin
					$display("%0t: last_of_byte, expected %0b, got %0b",
						$time, want_res.last, last_of_byte);
					err_cnt++;
				end
				if (stream_done !== want_res.done) begin
					$display("%0t: stream_done, expected %0b, got %0b",
						$time, want_res.done, stream_done);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction of any kind.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		dec_item_t        it;
		dir_row_t         row;
		logic [IDX_W-1:0] tree_root;
		logic [31:0]      rv;
		int               n;
		int               k;
		int               pick;

		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = OP_LOAD;
		node_index  = '0;
		left_child  = '0;
		right_child = '0;
		is_leaf     = 1'b0;
		leaf_symbol = '0;
		data_byte   = '0;
		valid_bits  = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		walk_pos    = '0;
		sym_count   = '0;
		root_reg    = '0;
		limit_reg   = '0;
		foreach (node_loaded[i])
			node_loaded[i] = 1'b0;

		// Directed transactions; node 0 becomes a leaf and serves as root.
		dir_tab.push_back(load_row(9'd0, 9'd511, 9'd511, 1'b1, 8'h5A));
		dir_tab.push_back(byte_row(OP_DECODE, 8'hFF, 4'd8, 1'b1, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(reg_row(REG_LIMIT, 32'hFFFF_FFFF));
		dir_tab.push_back(byte_row(OP_DECODE, 8'h00, 4'd3, 1'b1, 4'd3, 8'h5A, 1'b0));
		dir_tab.push_back(byte_row(OP_DECODE, 8'hFF, 4'd0, 1'b1, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(byte_row(OP_DECODE, 8'hAA, 4'd15, 1'b1, 4'd8, 8'h5A, 1'b0));
		dir_tab.push_back(byte_row(OP_UNUSED, 8'hFF, 4'd8, 1'b1, 4'd0, 8'h00, 1'b0));
		// A small tree rooted at the top index.
		dir_tab.push_back(load_row(9'd511, 9'd1, 9'd510, 1'b0, 8'hFF));
		dir_tab.push_back(load_row(9'd1, 9'd0, 9'd0, 1'b1, 8'h00));
		dir_tab.push_back(load_row(9'd510, 9'd2, 9'd3, 1'b0, 8'h00));
		dir_tab.push_back(load_row(9'd2, 9'd511, 9'd511, 1'b1, 8'hFF));
		dir_tab.push_back(load_row(9'd3, 9'd0, 9'd0, 1'b1, 8'h80));
		dir_tab.push_back(reg_row(REG_ROOT, 32'hFFFF_FFFF));
		dir_tab.push_back(reg_row(REG_LIMIT, 32'd5));
		dir_tab.push_back(byte_row(OP_START, 8'h00, 4'd0, 1'b0, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(byte_row(OP_DECODE, 8'h5A, 4'd8, 1'b0, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(byte_row(OP_DECODE, 8'h00, 4'd8, 1'b1, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(byte_row(OP_START, 8'h00, 4'd0, 1'b0, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(byte_row(OP_DECODE, 8'hFF, 4'd8, 1'b0, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(byte_row(OP_DECODE, 8'h80, 4'd1, 1'b0, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(byte_row(OP_DECODE, 8'h00, 4'd1, 1'b0, 4'd0, 8'h00, 1'b0));
		// Leaf root with a limit of one, then a limit of zero.
		dir_tab.push_back(reg_row(REG_ROOT, 32'd0));
		dir_tab.push_back(reg_row(REG_LIMIT, 32'd1));
		dir_tab.push_back(byte_row(OP_START, 8'h00, 4'd0, 1'b0, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(byte_row(OP_DECODE, 8'hFF, 4'd8, 1'b1, 4'd1, 8'h5A, 1'b1));
		dir_tab.push_back(reg_row(REG_LIMIT, 32'd0));
		dir_tab.push_back(byte_row(OP_START, 8'h00, 4'd0, 1'b0, 4'd0, 8'h00, 1'b0));
		dir_tab.push_back(byte_row(OP_DECODE, 8'hFF, 4'd8, 1'b1, 4'd0, 8'h00, 1'b0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.kind == ROW_REG) begin
				wait_idle();
				reg_access(row.reg_sel, row.reg_val);
			end else begin
				send_item(row.item, row.typed, row.exp_n, row.exp_sym, row.exp_done);
				idle_gap();
			end
		end

		// Random phases: usually a new tree, then new settings and one stream of bytes each.
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			wait_idle();
			tree_root = pick_loaded();
			if ($urandom_range(0, 9) < 7) begin
				n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 16);
				build_tree(n, tree_root);
				wait_idle();
				if ($urandom_range(0, 7) == 0)
					tree_root = pick_loaded();
			end
			rv = $urandom;
			if ($urandom_range(0, 1) == 0)
				rv = '0;
			rv[IDX_W-1:0] = tree_root;
			reg_access(REG_ROOT, rv);
			case ($urandom_range(0, 9))
				0:       rv = 32'd0;
				1:       rv = $urandom_range(1, 3);
				7:       rv = 32'hFFFF_FFFF;
				8:       rv = $urandom;
				9:       rv = $urandom_range(61, 200);
				default: rv = $urandom_range(4, 60);
			endcase
			reg_access(REG_LIMIT, rv);

			it    = random_item();
			it.op = OP_START;
			send_item(it, 1'b0, 4'd0, '0, 1'b0);
			idle_gap();

			// Mostly decodes, with ignored codes, restarts and stray loads.
			n = $urandom_range(4, 14);
			for (k = 0; k < n; k++) begin
				it   = random_item();
				pick = $urandom_range(0, 49);
				if (pick < 40) begin
					it.op = OP_DECODE;
					if ($urandom_range(0, 9) < 7)
						it.nbits = NBITS_W'(BYTE_BITS);
				end else if (pick < 44) begin
					it.op = OP_UNUSED;
				end else if (pick < 47) begin
					it.op = OP_START;
				end else begin
					// A stray load still points only at loaded nodes.
					it.op  = OP_LOAD;
					it.lft = pick_loaded();
					it.rgt = pick_loaded();
				end
				send_item(it, 1'b0, 4'd0, '0, 1'b0);
				no_idle = (rand_items >= RAND_ITEMS - CALM_TAIL);
				idle_gap();
			end
		end

		wait_idle();
		if (err_cnt == 0 && expected_syms.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
